### design/utn_pkg.sv
package utn_pkg;

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_DEL = 8'h7F;
  localparam logic [7:0] LEAD_C2   = 8'hC2;
  localparam logic [7:0] NBSP_A0   = 8'hA0;
  localparam logic [7:0] LEAD_E2   = 8'hE2;
  localparam logic [7:0] MID_80    = 8'h80;
  localparam logic [7:0] LSQ_98    = 8'h98;
  localparam logic [7:0] RSQ_99    = 8'h99;
  localparam logic [7:0] LDQ_9C    = 8'h9C;
  localparam logic [7:0] RDQ_9D    = 8'h9D;
  localparam logic [7:0] EN_93     = 8'h93;
  localparam logic [7:0] EM_94     = 8'h94;
  localparam logic [7:0] ELL_A6    = 8'hA6;
  localparam logic [7:0] MASK_E0   = 8'hE0;
  localparam logic [7:0] MASK_F0   = 8'hF0;
  localparam logic [7:0] PAT_C0    = 8'hC0;
  localparam logic [7:0] PAT_E0    = 8'hE0;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_QMARK = 7'h3F;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;

  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_TWO   = 2'd1;
  localparam logic [1:0] SKIP_THREE = 2'd2;
  localparam logic [1:0] SKIP_FOUR  = 2'd3;

  localparam logic [1:0] RUN_NONE  = 2'd0;
  localparam logic [1:0] RUN_ONE   = 2'd1;
  localparam logic [1:0] RUN_THREE = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_C2   = 5'b00010,
    PH_E2   = 5'b00100,
    PH_E280 = 5'b01000,
    PH_SKIP = 5'b10000
  } utn_phase_t;

  // one byte's output: a character repeated cnt times (cnt zero means nothing)
  typedef struct packed {
    logic [6:0] ch;
    logic [1:0] cnt;
  } utn_run_t;

endpackage

### design/utn_if.sv
interface utn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

### design/utn_decoder.sv
module utn_decoder
  import utn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       consume,
  output utn_run_t   run
);

  utn_phase_t phase, phase_next;
  logic [1:0] skip, skip_next;

  always_comb begin
    phase_next = phase;
    skip_next  = skip;
    run        = '{ch: CH_QMARK, cnt: RUN_NONE};
    unique case (phase)
      PH_C2: begin
        run        = '{ch: (in_byte == NBSP_A0) ? CH_SPACE : CH_QMARK, cnt: RUN_ONE};
        phase_next = PH_IDLE;
      end
      PH_E2: begin
        if (in_byte == MID_80 && !end_of_text) begin
          phase_next = PH_E280;
        end else begin
          run = '{ch: CH_QMARK, cnt: RUN_ONE};
          if (in_byte == MID_80) begin
            skip_next  = SKIP_NONE;
            phase_next = PH_IDLE;
          end else begin
            skip_next  = SKIP_TWO;
            phase_next = PH_SKIP;
          end
        end
      end
      PH_E280: begin
        phase_next = PH_IDLE;
        priority if (in_byte == LSQ_98 || in_byte == RSQ_99) begin
          run = '{ch: CH_APOS, cnt: RUN_ONE};
        end else if (in_byte == LDQ_9C || in_byte == RDQ_9D) begin
          run = '{ch: CH_QUOTE, cnt: RUN_ONE};
        end else if (in_byte == EN_93 || in_byte == EM_94) begin
          run = '{ch: CH_DASH, cnt: RUN_ONE};
        end else if (in_byte == ELL_A6) begin
          run = '{ch: CH_DOT, cnt: RUN_THREE};
        end else begin
          run = '{ch: CH_QMARK, cnt: RUN_NONE};
        end
      end
      PH_SKIP: begin
        skip_next  = (skip == SKIP_NONE) ? SKIP_NONE : skip - 2'd1;
        phase_next = (skip_next != SKIP_NONE) ? PH_SKIP : PH_IDLE;
      end
      default: begin
        priority if (in_byte >= PRINT_LO && in_byte < PRINT_DEL) begin
          run        = '{ch: in_byte[6:0], cnt: RUN_ONE};
          phase_next = PH_IDLE;
        end else if (in_byte == LEAD_C2) begin
          run.cnt    = end_of_text ? RUN_ONE : RUN_NONE;
          phase_next = PH_C2;
        end else if (in_byte == LEAD_E2) begin
          run.cnt    = end_of_text ? RUN_ONE : RUN_NONE;
          phase_next = PH_E2;
        end else begin
          run        = '{ch: CH_QMARK, cnt: RUN_ONE};
          phase_next = PH_SKIP;
          if ((in_byte & MASK_E0) == PAT_C0) begin
            skip_next = SKIP_TWO;
          end else if ((in_byte & MASK_F0) == PAT_E0) begin
            skip_next = SKIP_THREE;
          end else begin
            skip_next = SKIP_FOUR;
          end
        end
      end
    endcase
    if (end_of_text) begin
      phase_next = PH_IDLE;
      skip_next  = SKIP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      skip  <= SKIP_NONE;
    end else if (consume) begin
      phase <= phase_next;
      skip  <= skip_next;
    end
  end

endmodule

### design/utn_emitter.sv
module utn_emitter
  import utn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  utn_run_t  run_in,
  output logic      can_load,
  utn_out_if.source char_chan
);

  logic       run_valid;
  logic [6:0] ch;
  logic [1:0] cnt;
  logic       beat;

  assign beat     = char_chan.valid && char_chan.ready;
  assign can_load = !run_valid || (beat && cnt == RUN_ONE);

  assign char_chan.valid       = run_valid;
  assign char_chan.out_char    = ch;
  assign char_chan.last_of_run = (cnt == RUN_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (load) begin
      run_valid <= 1'b1;
    end else if (beat && cnt == RUN_ONE) begin
      run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch  <= run_in.ch;
      cnt <= run_in.cnt;
    end else if (beat) begin
      cnt <= cnt - 2'd1;
    end
  end

endmodule

### design/utf8_to_ascii_normalizer_core.sv
// Bytes enter the input register; their characters leave from the output register.
// Throughput: one byte per cycle while each byte yields at most one character and
// the output is not stalled; an ellipsis holds the output register for its three
// dots, one character per beat. Bytes that yield nothing never wait on the output.
// Reset: synchronous, active high; clears the sequence phase, skip count and
// both valid flags.
module utf8_to_ascii_normalizer_core
  import utn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  utn_in_if.sink   byte_chan,
  utn_out_if.source char_chan
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       consume;
  logic       can_load;
  utn_run_t   run;

  assign consume         = in_valid && (run.cnt == RUN_NONE || can_load);
  assign byte_chan.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_chan.ready) begin
      in_valid <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_chan.valid && byte_chan.ready) begin
      in_byte <= byte_chan.in_byte;
      in_eot  <= byte_chan.end_of_text;
    end
  end

  utn_decoder u_dec (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .end_of_text (in_eot),
    .consume     (consume),
    .run         (run)
  );

  utn_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && run.cnt != RUN_NONE),
    .run_in    (run),
    .can_load  (can_load),
    .char_chan (char_chan)
  );

endmodule

### design/utn_checker.sv
module utn_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("output payload changed while stalled");

  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= 7'h20 && out_char != 7'h7F))
    else $error("non-printable character emitted");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_to_ascii_normalizer_core utn_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (char_chan.valid),
  .out_ready (char_chan.ready),
  .out_char  (char_chan.out_char),
  .out_last  (char_chan.last_of_run)
);
